[hw/rtl/cbyp_pkg.sv]
package cbyp_pkg;

    // Default angle width, a full turn is 2**ANGLE_BITS
    localparam int ANGLE_BITS_DEF = 16;
    // Fixed-point fraction of the vector words (Q2.14)
    localparam int FRAC_BITS = 14;
    localparam int VEC_BITS = 16;
    localparam int TRIG_FRAC = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W = 34;
    localparam int QDEPTH = 4;
    localparam int SAT_W = 44;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_X   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Y   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Z   = 3'd5;

    // Arctangent of 2**-i in 32-bit turn units
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cord_t;

    // Sine and cosine of yaw and pitch, Q30
    typedef struct packed {
        logic signed [31:0] c_yaw;
        logic signed [31:0] s_yaw;
        logic signed [31:0] c_pitch;
        logic signed [31:0] s_pitch;
    } trig_t;

    typedef struct packed {
        logic signed [VEC_BITS-1:0] x;
        logic signed [VEC_BITS-1:0] y;
        logic signed [VEC_BITS-1:0] z;
    } vec16_t;

    // Fold the turn into [-1/4, 1/4) and load the gain-compensated start
    function automatic cord_t cord_init(input logic [31:0] t);
        cord_t r;
        logic [31:0] tf;
        tf = {t[31] ^ (t[31] ^ t[30]), t[30:0]};
        r.x = CORDIC_GAIN;
        r.y = '0;
        r.z = {{(CORDIC_W-32){tf[31]}}, tf};
        return r;
    endfunction

    // One CORDIC rotation toward z = 0
    function automatic cord_t cordic_step(input cord_t a, input int i);
        cord_t r;
        logic signed [CORDIC_W-1:0] ang;
        ang = $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[i]});
        if (!a.z[CORDIC_W-1])
        begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - ang;
        end
        else
        begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + ang;
        end
        return r;
    endfunction

    // Clamp to the signed 16-bit output range
    function automatic logic signed [VEC_BITS-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32767);
        lo = -SAT_W'(32768);
        if (v > hi)
            return 16'sh7FFF;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[VEC_BITS-1:0];
    endfunction

endpackage

[hw/rtl/cbyp_front.sv]
module cbyp_front #(
    parameter int ANGLE_BITS = cbyp_pkg::ANGLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [ANGLE_BITS-1:0]        yaw,
    input  logic signed [ANGLE_BITS-1:0] pitch,
    input  logic                         q_full,
    output logic                         push,
    output cbyp_pkg::trig_t              trig
);
    import cbyp_pkg::*;

    localparam int PAD = 32 - ANGLE_BITS;
    localparam logic signed [ANGLE_BITS-1:0] PITCH_LIM =
        ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));
    localparam logic signed [ANGLE_BITS-1:0] PITCH_LIM_N = -PITCH_LIM;

    logic signed [ANGLE_BITS-1:0] pitch_c;
    logic [31:0] t_yaw;
    logic [31:0] t_pitch;
    logic adv;
    logic [CORDIC_STEPS:0] valid_reg;
    cord_t yaw_reg   [0:CORDIC_STEPS];
    cord_t pitch_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] flip_yaw_reg;
    logic [CORDIC_STEPS:0] flip_pitch_reg;

    // Clamp pitch to a quarter turn either way
    always_comb
    begin
        if (pitch > PITCH_LIM)
            pitch_c = PITCH_LIM;
        else if (pitch < PITCH_LIM_N)
            pitch_c = PITCH_LIM_N;
        else
            pitch_c = pitch;
    end

    assign t_yaw   = {yaw, {PAD{1'b0}}};
    assign t_pitch = {pitch_c, {PAD{1'b0}}};

    // Hold the whole pipe when the last word cannot enter the queue
    assign adv        = !(valid_reg[CORDIC_STEPS] && q_full);
    assign item_stall = !adv;
    assign push       = valid_reg[CORDIC_STEPS] && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], item_valid};
    end

    // Advance the CORDIC stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg[0]        <= cord_init(t_yaw);
            pitch_reg[0]      <= cord_init(t_pitch);
            flip_yaw_reg[0]   <= t_yaw[31] ^ t_yaw[30];
            flip_pitch_reg[0] <= t_pitch[31] ^ t_pitch[30];
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                yaw_reg[k]        <= cordic_step(yaw_reg[k-1], k - 1);
                pitch_reg[k]      <= cordic_step(pitch_reg[k-1], k - 1);
                flip_yaw_reg[k]   <= flip_yaw_reg[k-1];
                flip_pitch_reg[k] <= flip_pitch_reg[k-1];
            end
        end
    end

    // Undo the half-turn fold
    always_comb
    begin
        trig.c_yaw   = 32'(flip_yaw_reg[CORDIC_STEPS] ? -yaw_reg[CORDIC_STEPS].x
                                                      : yaw_reg[CORDIC_STEPS].x);
        trig.s_yaw   = 32'(flip_yaw_reg[CORDIC_STEPS] ? -yaw_reg[CORDIC_STEPS].y
                                                      : yaw_reg[CORDIC_STEPS].y);
        trig.c_pitch = 32'(flip_pitch_reg[CORDIC_STEPS] ? -pitch_reg[CORDIC_STEPS].x
                                                        : pitch_reg[CORDIC_STEPS].x);
        trig.s_pitch = 32'(flip_pitch_reg[CORDIC_STEPS] ? -pitch_reg[CORDIC_STEPS].y
                                                        : pitch_reg[CORDIC_STEPS].y);
    end

endmodule

[hw/rtl/cbyp_queue.sv]
module cbyp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cbyp_pkg::trig_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output cbyp_pkg::trig_t head
);
    import cbyp_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    trig_t entries_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/cbyp_back.sv]
module cbyp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cbyp_pkg::trig_t        head,
    output logic                   pop,
    input  cbyp_pkg::vec16_t       v0,
    input  cbyp_pkg::vec16_t       u0,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic signed [15:0]     view_x,
    output logic signed [15:0]     view_y,
    output logic signed [15:0]     view_z,
    output logic signed [15:0]     side_x,
    output logic signed [15:0]     side_y,
    output logic signed [15:0]     side_z,
    output logic signed [15:0]     up_x,
    output logic signed [15:0]     up_y,
    output logic signed [15:0]     up_z
);
    import cbyp_pkg::*;

    localparam logic signed [33:0] HALF_C1 = 34'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [53:0] HALF_B2 = 54'sd1 <<< (TRIG_FRAC - 1);
    localparam logic signed [41:0] HALF_C3 = 42'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [57:0] HALF_B3 = 58'sd1 <<< (TRIG_FRAC - 1);
    localparam logic signed [57:0] HALF_C4 = 58'sd1 <<< (FRAC_BITS - 1);

    logic [4:0] valid_reg;
    logic adv;
    logic load_out;

    // Stage 1: trig words and initial side vector
    trig_t t1_reg;
    logic signed [19:0] n0x_reg, n0y_reg, n0z_reg;
    logic signed [33:0] n0x_s, n0y_s, n0z_s;
    // Stage 2: view after yaw
    trig_t t2_reg;
    logic signed [23:0] v1x_reg, v1y_reg, v1z_reg;
    logic signed [53:0] v1x_s, v1y_s, v1z_s;
    // Stage 3: side and tilted view
    logic signed [27:0] sdx_reg, sdy_reg, sdz_reg;
    logic signed [27:0] v2x_reg, v2y_reg, v2z_reg;
    logic signed [41:0] sdx_s, sdy_s, sdz_s;
    logic signed [57:0] v2x_s, v2y_s, v2z_s;
    // Stage 4: side and view copies; the up vector registers belong to stage 5
    logic signed [27:0] sd4x_reg, sd4y_reg, sd4z_reg;
    logic signed [27:0] v24x_reg, v24y_reg, v24z_reg;
    logic signed [43:0] upx_reg, upy_reg, upz_reg;
    logic signed [57:0] upx_s, upy_s, upz_s;

    // Hold the back pipe only when its last word cannot reach the output
    assign adv      = !(valid_reg[4] && res_valid && res_stall);
    assign pop      = q_valid && adv;
    assign load_out = !res_valid || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            if (adv)
                valid_reg <= {valid_reg[3:0], q_valid};
            if (load_out)
                res_valid <= valid_reg[4];
        end
    end

    always_comb
    begin
        n0x_s = v0.y * u0.z - v0.z * u0.y + HALF_C1;
        n0y_s = v0.z * u0.x - v0.x * u0.z + HALF_C1;
        n0z_s = v0.x * u0.y - v0.y * u0.x + HALF_C1;
        v1x_s = t1_reg.c_yaw * v0.x + t1_reg.s_yaw * n0x_reg + HALF_B2;
        v1y_s = t1_reg.c_yaw * v0.y + t1_reg.s_yaw * n0y_reg + HALF_B2;
        v1z_s = t1_reg.c_yaw * v0.z + t1_reg.s_yaw * n0z_reg + HALF_B2;
        sdx_s = v1y_reg * u0.z - v1z_reg * u0.y + HALF_C3;
        sdy_s = v1z_reg * u0.x - v1x_reg * u0.z + HALF_C3;
        sdz_s = v1x_reg * u0.y - v1y_reg * u0.x + HALF_C3;
        v2x_s = t2_reg.c_pitch * v1x_reg - t2_reg.s_pitch * u0.x + HALF_B3;
        v2y_s = t2_reg.c_pitch * v1y_reg - t2_reg.s_pitch * u0.y + HALF_B3;
        v2z_s = t2_reg.c_pitch * v1z_reg - t2_reg.s_pitch * u0.z + HALF_B3;
        upx_s = sd4y_reg * v24z_reg - sd4z_reg * v24y_reg + HALF_C4;
        upy_s = sd4z_reg * v24x_reg - sd4x_reg * v24z_reg + HALF_C4;
        upz_s = sd4x_reg * v24y_reg - sd4y_reg * v24x_reg + HALF_C4;
    end

    // Advance the vector stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= head;
            n0x_reg  <= n0x_s[33:14];
            n0y_reg  <= n0y_s[33:14];
            n0z_reg  <= n0z_s[33:14];
            t2_reg   <= t1_reg;
            v1x_reg  <= v1x_s[53:30];
            v1y_reg  <= v1y_s[53:30];
            v1z_reg  <= v1z_s[53:30];
            sdx_reg  <= sdx_s[41:14];
            sdy_reg  <= sdy_s[41:14];
            sdz_reg  <= sdz_s[41:14];
            v2x_reg  <= v2x_s[57:30];
            v2y_reg  <= v2y_s[57:30];
            v2z_reg  <= v2z_s[57:30];
            sd4x_reg <= sdx_reg;
            sd4y_reg <= sdy_reg;
            sd4z_reg <= sdz_reg;
            v24x_reg <= v2x_reg;
            v24y_reg <= v2y_reg;
            v24z_reg <= v2z_reg;
            upx_reg  <= upx_s[57:14];
            upy_reg  <= upy_s[57:14];
            upz_reg  <= upz_s[57:14];
        end
    end

    // Saturate into the output word; stage 5 keeps side and view beside up
    logic signed [27:0] sd5x_reg, sd5y_reg, sd5z_reg;
    logic signed [27:0] v25x_reg, v25y_reg, v25z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd5x_reg <= sd4x_reg;
            sd5y_reg <= sd4y_reg;
            sd5z_reg <= sd4z_reg;
            v25x_reg <= v24x_reg;
            v25y_reg <= v24y_reg;
            v25z_reg <= v24z_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            view_x <= sat16({{(SAT_W-28){v25x_reg[27]}}, v25x_reg});
            view_y <= sat16({{(SAT_W-28){v25y_reg[27]}}, v25y_reg});
            view_z <= sat16({{(SAT_W-28){v25z_reg[27]}}, v25z_reg});
            side_x <= sat16({{(SAT_W-28){sd5x_reg[27]}}, sd5x_reg});
            side_y <= sat16({{(SAT_W-28){sd5y_reg[27]}}, sd5y_reg});
            side_z <= sat16({{(SAT_W-28){sd5z_reg[27]}}, sd5z_reg});
            up_x   <= sat16(upx_reg);
            up_y   <= sat16(upy_reg);
            up_z   <= sat16(upz_reg);
        end
    end

endmodule

[hw/rtl/camera_basis_from_yaw_pitch.sv]
// Channel | Direction | Handshake             | Word
// item    | in        | item_valid/item_stall | yaw, pitch
// res     | out       | res_valid/res_stall   | view_*, side_*, up_*
// cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item per cycle sustained while item_stall is low; with an empty queue a result
// becomes valid after passing, from the accepting edge, 30 more CORDIC stages, one queue
// slot, five vector stages and one output register.
// A four-word queue lets the CORDIC pipe run while the output is stalled;
// item_stall rises only when that queue is full with a word waiting to enter.
// Reset clears all valid flags and loads the default view and up vectors.
module camera_basis_from_yaw_pitch #(
    parameter int ANGLE_BITS = cbyp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [ANGLE_BITS-1:0]               yaw,
    input  logic signed [ANGLE_BITS-1:0]        pitch,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [15:0]                  view_x,
    output logic signed [15:0]                  view_y,
    output logic signed [15:0]                  view_z,
    output logic signed [15:0]                  side_x,
    output logic signed [15:0]                  side_y,
    output logic signed [15:0]                  side_z,
    output logic signed [15:0]                  up_x,
    output logic signed [15:0]                  up_y,
    output logic signed [15:0]                  up_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbyp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [15:0]                         cfg_data
);
    import cbyp_pkg::*;

    vec16_t v0_reg;
    vec16_t u0_reg;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_not_empty;
    trig_t  front_trig;
    trig_t  q_head;

    assign cfg_ready = 1'b1;

    // Write the initial vectors; unknown indexes drop the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= '{x: 16'sd16384, y: 16'sd0, z: 16'sd0};
            u0_reg <= '{x: 16'sd0, y: 16'sd0, z: 16'sd16384};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VIEW_X: v0_reg.x <= cfg_data;
                REG_VIEW_Y: v0_reg.y <= cfg_data;
                REG_VIEW_Z: v0_reg.z <= cfg_data;
                REG_UP_X:   u0_reg.x <= cfg_data;
                REG_UP_Y:   u0_reg.y <= cfg_data;
                REG_UP_Z:   u0_reg.z <= cfg_data;
                default:    ;
            endcase
        end
    end

    cbyp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .yaw        (yaw),
        .pitch      (pitch),
        .q_full     (q_full),
        .push       (q_push),
        .trig       (front_trig)
    );

    cbyp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_trig),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cbyp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .v0        (v0_reg),
        .u0        (u0_reg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .view_x    (view_x),
        .view_y    (view_y),
        .view_z    (view_z),
        .side_x    (side_x),
        .side_y    (side_y),
        .side_z    (side_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z)
    );

endmodule

[hw/rtl/cbyp_checker.sv]
module cbyp_checker #(
    parameter int ANGLE_BITS = cbyp_pkg::ANGLE_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic [ANGLE_BITS-1:0]        yaw,
    input logic signed [ANGLE_BITS-1:0] pitch,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic signed [15:0]           view_x,
    input logic signed [15:0]           view_y,
    input logic signed [15:0]           view_z,
    input logic signed [15:0]           side_x,
    input logic signed [15:0]           side_y,
    input logic signed [15:0]           side_z,
    input logic signed [15:0]           up_x,
    input logic signed [15:0]           up_y,
    input logic signed [15:0]           up_z,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);

    // A stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid &&
        $stable({view_x, view_y, view_z, side_x, side_y, side_z, up_x, up_y, up_z}))
        else $error("result word changed under stall");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

    // Input is never held off while the output side keeps taking words
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(res_stall) && !$past(res_stall, 2) && !$past(res_stall, 3)
        && !$past(res_stall, 4) && !$past(res_stall, 5) && $past(rst_n, 5)
        |-> !item_stall)
        else $error("input stalled with output flowing");

    // Configuration port always takes a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind camera_basis_from_yaw_pitch cbyp_checker #(.ANGLE_BITS(ANGLE_BITS)) u_cbyp_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cbyp_pkg::*;

    localparam int ABITS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    // Arctangent of 2**-i in 32-bit turn units
    localparam longint ATAN_TBL [0:29] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
    } angles_t;

    typedef struct {
        logic signed [15:0] f [9];
    } basis_t;

    typedef struct {
        longint c [3];
    } vec_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [ABITS-1:0] yaw;
    logic signed [ABITS-1:0] pitch;
    logic res_valid;
    logic res_stall;
    logic signed [15:0] view_x, view_y, view_z;
    logic signed [15:0] side_x, side_y, side_z;
    logic signed [15:0] up_x, up_y, up_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [15:0] cfg_data;

    camera_basis_from_yaw_pitch uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .yaw(yaw), .pitch(pitch),
        .res_valid(res_valid), .res_stall(res_stall),
        .view_x(view_x), .view_y(view_y), .view_z(view_z),
        .side_x(side_x), .side_y(side_y), .side_z(side_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model copy of the initial view and up vectors
    longint basis_init [6];

    angles_t pending_words [$];
    basis_t expected_basis [$];
    int errors;
    int sent_count;
    int got_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_phase;
    bit stall_mode;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // CORDIC sine and cosine of a 32-bit turn angle, Q30
    function automatic void turn_sincos(input logic [31:0] t, output longint c,
                                        output longint s);
        bit flip;
        longint x, y, z, xn;
        flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
        if (flip)
            t = t - 32'h80000000;
        z = longint'($signed(t));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                xn = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - ATAN_TBL[i];
            end
            else
            begin
                xn = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + ATAN_TBL[i];
            end
            x = xn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic vec_t cross_q14(vec_t a, vec_t b);
        vec_t r;
        r.c[0] = round_shift(a.c[1] * b.c[2] - a.c[2] * b.c[1], FRAC_BITS);
        r.c[1] = round_shift(a.c[2] * b.c[0] - a.c[0] * b.c[2], FRAC_BITS);
        r.c[2] = round_shift(a.c[0] * b.c[1] - a.c[1] * b.c[0], FRAC_BITS);
        return r;
    endfunction

    function automatic vec_t mix_q30(longint ka, vec_t a, longint kb, vec_t b);
        vec_t r;
        for (int k = 0; k < 3; k++)
            r.c[k] = round_shift(ka * a.c[k] + kb * b.c[k], TRIG_FRAC);
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Compute the camera basis for one pair of angles
    function automatic basis_t camera_basis(angles_t a);
        basis_t r;
        longint p, ch, sh, cp, sp;
        logic [31:0] pt;
        vec_t v0, u0, n0, v1, sd, v2, nu;
        p = longint'($signed(a.pitch));
        if (p > 16384)
            p = 16384;
        if (p < -16384)
            p = -16384;
        pt = {p[15:0], 16'h0};
        turn_sincos({a.yaw, 16'h0}, ch, sh);
        turn_sincos(pt, cp, sp);
        for (int k = 0; k < 3; k++)
        begin
            v0.c[k] = basis_init[k];
            u0.c[k] = basis_init[3 + k];
        end
        n0 = cross_q14(v0, u0);
        v1 = mix_q30(ch, v0, sh, n0);
        sd = cross_q14(v1, u0);
        v2 = mix_q30(cp, v1, -sp, u0);
        nu = cross_q14(sd, v2);
        for (int k = 0; k < 3; k++)
        begin
            r.f[k] = clamp16(v2.c[k]);
            r.f[3 + k] = clamp16(sd.c[k]);
            r.f[6 + k] = clamp16(nu.c[k]);
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: send words in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            yaw <= '0;
            pitch <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                sent_count <= sent_count + 1;
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() > 0)
            begin
                angles_t w;
                w = pending_words.pop_front();
                expected_basis.push_back(camera_basis(w));
                item_valid <= 1'b1;
                yaw <= w.yaw;
                pitch <= w.pitch;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver stall pattern: alternate stretches of free flow and random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_phase <= 0;
            stall_mode <= 1'b0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                stall_phase <= $urandom_range(20, 150);
                stall_mode <= ~stall_mode;
            end
            else
                stall_phase <= stall_phase - 1;
            res_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // Monitor: compare each word against the oldest expected basis
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_valid && !res_stall)
            begin
                basis_t got;
                basis_t exp_b;
                int bad;
                bad = 0;
                got.f = '{view_x, view_y, view_z, side_x, side_y, side_z,
                          up_x, up_y, up_z};
                got_count <= got_count + 1;
                if (expected_basis.size() == 0)
                begin
                    $display("%0t: unexpected result word", $realtime);
                    bad = 1;
                end
                else
                begin
                    exp_b = expected_basis.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got.f[k] !== exp_b.f[k])
                        begin
                            $display("%0t: field %0d expected %0d actual %0d",
                                     $realtime, k, exp_b.f[k], got.f[k]);
                            bad = bad + 1;
                        end
                end
                if (bad != 0)
                    errors <= errors + bad;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d words outstanding",
                         expected_basis.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx <= REG_UP_Z)
            basis_init[idx] = longint'($signed(val));
        @(posedge clk);
    endtask

    task automatic load_basis(input logic [15:0] vx, vy, vz, ux, uy, uz);
        write_reg(REG_VIEW_X, vx);
        write_reg(REG_VIEW_Y, vy);
        write_reg(REG_VIEW_Z, vz);
        write_reg(REG_UP_X, ux);
        write_reg(REG_UP_Y, uy);
        write_reg(REG_UP_Z, uz);
    endtask

    // Hold until all words are consumed and checked, then let the pipe drain
    task automatic drain();
        while (pending_words.size() > 0 || item_valid || expected_basis.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic angles_t random_angles();
        angles_t a;
        a.yaw = 16'($urandom);
        case ($urandom_range(0, 3))
            0: a.pitch = 16'($urandom_range(0, 32767)) - 16'd16384;
            1:
            begin
                a.pitch = 16'($urandom_range(16380, 16388));
                if ($urandom_range(0, 1) == 0)
                    a.pitch = -a.pitch;
            end
            default: a.pitch = 16'($urandom);
        endcase
        return a;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(random_angles());
        drain();
    endtask

    initial
    begin
        logic [15:0] yaw_edges [8];
        logic [15:0] pitch_edges [8];
        errors = 0;
        sent_count = 0;
        got_count = 0;
        idle_cycles = 0;
        basis_init = '{16384, 0, 0, 0, 0, 16384};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: angle extremes, quadrant borders and the pitch clamp
        yaw_edges = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF,
                      16'hC000, 16'hFFFF};
        pitch_edges = '{16'h0000, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF, 16'h7FFF,
                        16'h8000, 16'h2000};
        for (int i = 0; i < 8; i++)
            pending_words.push_back('{yaw: yaw_edges[i], pitch: pitch_edges[i]});
        pending_words.push_back('{yaw: 16'h5555, pitch: 16'hAAAA});
        pending_words.push_back('{yaw: 16'hAAAA, pitch: 16'h5555});
        drain();

        // Parallel view and up: side and up collapse to zero
        load_basis(16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        pending_words.push_back('{yaw: 16'h1234, pitch: 16'h0800});
        pending_words.push_back('{yaw: 16'hFFFF, pitch: 16'hF000});
        drain();

        // Extreme register values to drive saturation
        load_basis(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        pending_words.push_back('{yaw: 16'h0000, pitch: 16'h0000});
        pending_words.push_back('{yaw: 16'h2000, pitch: 16'h4000});
        pending_words.push_back('{yaw: 16'hE000, pitch: 16'hC000});
        random_phase(200);

        load_basis(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        random_phase(150);

        // Unknown register indexes are dropped
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        load_basis(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        random_phase(500);

        // Random unnormalized vectors
        for (int p = 0; p < 3; p++)
        begin
            load_basis(16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
            random_phase(200);
        end

        $display("run checked %0d basis words over %0d sent angle pairs", got_count,
                 sent_count);
        $display("covered pitch clamp, quadrant borders, parallel and extreme vectors");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
